FILE: src/i2cmts_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
package i2cmts_pkg;

	// Event and request codes carried on the input tuser
	typedef enum logic [3:0] {
		OP_WRITE     = 4'd0,
		OP_READ      = 4'd1,
		OP_REG_WRITE = 4'd2,
		OP_REG_READ  = 4'd3,
		OP_TX_READY  = 4'd4,
		OP_RX_READY  = 4'd5,
		OP_STOP      = 4'd6,
		OP_NACK      = 4'd7,
		OP_LOAD      = 4'd8
	} op_t;

	// Result kinds carried on the output tuser
	typedef enum logic [2:0] {
		K_NONE  = 3'd0,
		K_START = 3'd1,
		K_TX    = 3'd2,
		K_RX    = 3'd3,
		K_DONE  = 3'd4,
		K_BUSY  = 3'd5,
		K_NACK  = 3'd6
	} kind_t;

	// Kind of the transfer in progress
	typedef enum logic [2:0] {
		XF_WRITE     = 3'd0,
		XF_READ      = 3'd1,
		XF_REG_WRITE = 3'd2,
		XF_REG_READ  = 3'd3,
		XF_NONE      = 3'd4
	} xfer_t;

	// Sequencer phase, one-hot
	typedef enum logic [3:0] {
		PH_READY = 4'b0001,
		PH_ADDR  = 4'b0010,
		PH_TX    = 4'b0100,
		PH_RX    = 4'b1000
	} phase_t;

	// Encoded phase values reported in the result
	localparam logic [1:0] PhaseCodeReady = 2'd0;
	localparam logic [1:0] PhaseCodeAddr  = 2'd1;
	localparam logic [1:0] PhaseCodeTx    = 2'd2;
	localparam logic [1:0] PhaseCodeRx    = 2'd3;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [6:0] cmd_address;
		logic [7:0] cmd_nbytes;
		logic       cmd_read;
		logic [7:0] tx_data;
		logic [7:0] rx_out;
		logic [7:0] rx_index;
		logic [1:0] done_kind;
		logic [1:0] phase;
	} res_t;

	// Access to the transmit buffer
	typedef struct packed {
		logic       wr_en;
		logic       rd_en;
		logic [7:0] wr_idx;
		logic [7:0] rd_idx;
		logic [7:0] wr_data;
	} buf_req_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_READY: code = PhaseCodeReady;
			PH_ADDR:  code = PhaseCodeAddr;
			PH_TX:    code = PhaseCodeTx;
			PH_RX:    code = PhaseCodeRx;
			default:  code = PhaseCodeReady;
		endcase
		return code;
	endfunction

endpackage

FILE: src/i2cmts_tx_buffer.sv
// Transmit byte buffer with index wrap and registered read data.
module i2cmts_tx_buffer #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                clk,
	input  i2cmts_pkg::buf_req_t req,
	output logic [7:0]          rd_data
);
	import i2cmts_pkg::*;

	localparam int AddrWidth = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [16:0] Recip = 17'(65536 / BUFFER_DEPTH);
	localparam logic [15:0] Depth16 = 16'(BUFFER_DEPTH);
	localparam logic [8:0] Depth9 = 9'(BUFFER_DEPTH);

	logic [7:0] mem [BUFFER_DEPTH];
	logic [AddrWidth-1:0] wr_addr;
	logic [AddrWidth-1:0] rd_addr;

	// Reduce an eight-bit index modulo the depth: reciprocal estimate, then one fixup
	function automatic logic [AddrWidth-1:0] wrap_idx(input logic [7:0] x);
		logic [24:0] prod;
		logic [7:0]  quot;
		logic [15:0] back;
		logic [7:0]  rem;
		prod = 25'(x) * 25'(Recip);
		quot = prod[23:16];
		back = 16'(quot) * Depth16;
		rem  = x - back[7:0];
		if ({1'b0, rem} >= Depth9) begin
			rem = 8'(9'({1'b0, rem}) - Depth9);
		end
		return AddrWidth'(rem);
	endfunction

	assign wr_addr = wrap_idx(req.wr_idx);
	assign rd_addr = wrap_idx(req.rd_idx);

	// Write a loaded byte, read the next byte to send
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: event decode, transfer state, result stages.
// Results: a result passes through two register stages (res_s1, res_s2) after its event is accepted.
// Throughput: one event per cycle while s_tready is high (a stalled output holds it low); each
// event is one update of the transfer state and at most one access of the transmit buffer port.
// Reset clears the phase and all transfer state; transmit buffer contents stay undefined.
module i2c_master_transfer_sequencer #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bus_busy, dev_address, reg_address, reg_address_bytes, byte_count,
	// rx_data, load_index, load_data, zero pad
	input  logic [63:0] s_tdata,
	// op
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cmd_address, cmd_nbytes, cmd_read, tx_data, rx_out, rx_index,
	// done_kind, phase, zero pad
	output logic [47:0] m_tdata,
	// kind
	output logic [2:0]  m_tuser
);
	import i2cmts_pkg::*;

	// Input fields
	logic [3:0]  op;
	logic        bus_busy;
	logic [6:0]  dev_address;
	logic [15:0] reg_address;
	logic [1:0]  reg_address_bytes;
	logic [7:0]  byte_count;
	logic [7:0]  rx_data;
	logic [7:0]  load_index;
	logic [7:0]  load_data;

	// Transfer state
	phase_t      phase_q, phase_d;
	xfer_t       xfer_q, xfer_d;
	logic [2:0]  xfer_bits;
	logic [6:0]  target_q, target_d;
	logic [15:0] regaddr_q, regaddr_d;
	logic [1:0]  regbytes_q, regbytes_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [1:0]  acnt_q, acnt_d;

	// Result stages
	res_t        res_d, res_s1, res_s2;
	res_t        res_mrg;
	logic        use_mem_d, use_mem_s1;
	logic        valid_s1, valid_s2;
	logic        accept, adv_s2;
	logic        done_ok;
	logic [2:0]  acnt_p1, acnt_p2;

	buf_req_t    buf_req;
	logic [7:0]  buf_rd_data;

	assign op                = s_tuser;
	assign bus_busy          = s_tdata[0];
	assign dev_address       = s_tdata[7:1];
	assign reg_address       = s_tdata[23:8];
	assign reg_address_bytes = s_tdata[25:24];
	assign byte_count        = s_tdata[33:26];
	assign rx_data           = s_tdata[41:34];
	assign load_index        = s_tdata[49:42];
	assign load_data         = s_tdata[57:50];

	assign xfer_bits = xfer_q;
	assign acnt_p1   = {1'b0, acnt_q} + 3'd1;
	assign acnt_p2   = {1'b0, acnt_q} + 3'd2;

	// Handshake: stage one refills when empty or moving on
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	// Decode one event against the transfer state
	always_comb begin
		phase_d    = phase_q;
		xfer_d     = xfer_q;
		target_d   = target_q;
		regaddr_d  = regaddr_q;
		regbytes_d = regbytes_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		acnt_d     = acnt_q;
		res_d      = '0;
		res_d.kind = K_NONE;
		use_mem_d  = 1'b0;
		done_ok    = 1'b0;

		case (op) inside
			OP_WRITE, OP_READ, OP_REG_WRITE, OP_REG_READ: begin
				if (bus_busy || phase_q != PH_READY) begin
					res_d.kind = K_BUSY;
				end else begin
					xfer_d            = xfer_t'({1'b0, op[1:0]});
					target_d          = dev_address;
					len_d             = byte_count;
					cnt_d             = '0;
					acnt_d            = '0;
					res_d.kind        = K_START;
					res_d.cmd_address = dev_address;
					if (op[1]) begin
						regaddr_d        = reg_address;
						regbytes_d       = reg_address_bytes;
						phase_d          = PH_ADDR;
						res_d.cmd_nbytes = {6'd0, reg_address_bytes};
						res_d.cmd_read   = 1'b0;
					end else begin
						regaddr_d        = '0;
						regbytes_d       = '0;
						phase_d          = op[0] ? PH_RX : PH_TX;
						res_d.cmd_nbytes = byte_count;
						res_d.cmd_read   = op[0];
					end
				end
			end
			OP_TX_READY: begin
				if (phase_q == PH_ADDR) begin
					// Send register address bytes MSB first
					res_d.kind = K_TX;
					if ({1'b0, regbytes_q} == acnt_p1) begin
						res_d.tx_data = regaddr_q[7:0];
					end else if ({1'b0, regbytes_q} == acnt_p2) begin
						res_d.tx_data = regaddr_q[15:8];
					end
					acnt_d = acnt_q + 2'd1;
				end else if (phase_q == PH_TX) begin
					res_d.kind = K_TX;
					use_mem_d  = 1'b1;
					cnt_d      = cnt_q + 8'd1;
				end
			end
			OP_RX_READY: begin
				if (phase_q == PH_RX) begin
					res_d.kind     = K_RX;
					res_d.rx_out   = rx_data;
					res_d.rx_index = len_q - 8'd1 - cnt_q;
					cnt_d          = cnt_q + 8'd1;
				end
			end
			OP_STOP: begin
				if (phase_q == PH_ADDR) begin
					// Restart for the data phase of a register transfer
					if (xfer_q == XF_REG_WRITE || xfer_q == XF_REG_READ) begin
						phase_d           = (xfer_q == XF_REG_READ) ? PH_RX : PH_TX;
						res_d.kind        = K_START;
						res_d.cmd_address = target_q;
						res_d.cmd_nbytes  = len_q;
						res_d.cmd_read    = (xfer_q == XF_REG_READ);
					end
				end else if (phase_q == PH_TX || phase_q == PH_RX) begin
					if (phase_q == PH_TX) begin
						done_ok = (xfer_q == XF_WRITE) || (xfer_q == XF_REG_WRITE);
					end else begin
						done_ok = (xfer_q == XF_READ) || (xfer_q == XF_REG_READ);
					end
					if (done_ok) begin
						phase_d         = PH_READY;
						xfer_d          = XF_NONE;
						target_d        = '0;
						regaddr_d       = '0;
						regbytes_d      = '0;
						len_d           = '0;
						cnt_d           = '0;
						acnt_d          = '0;
						res_d.kind      = K_DONE;
						res_d.done_kind = xfer_bits[1:0];
					end
				end
			end
			OP_NACK: begin
				res_d.kind = K_NACK;
			end
			default: begin
			end
		endcase

		res_d.phase = phase_code(phase_d);
	end

	// Drive the buffer port from accepted events only
	always_comb begin
		buf_req         = '0;
		buf_req.wr_en   = accept && (op == OP_LOAD);
		buf_req.wr_idx  = load_index;
		buf_req.wr_data = load_data;
		buf_req.rd_en   = accept && use_mem_d;
		buf_req.rd_idx  = cnt_q;
	end

	i2cmts_tx_buffer #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_tx_buffer (
		.clk     (clk),
		.req     (buf_req),
		.rd_data (buf_rd_data)
	);

	// Advance transfer state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_READY;
			xfer_q     <= XF_NONE;
			target_q   <= '0;
			regaddr_q  <= '0;
			regbytes_q <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			acnt_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			xfer_q     <= xfer_d;
			target_q   <= target_d;
			regaddr_q  <= regaddr_d;
			regbytes_q <= regbytes_d;
			len_q      <= len_d;
			cnt_q      <= cnt_d;
			acnt_q     <= acnt_d;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Merge buffer data into a transmit byte result
	always_comb begin
		res_mrg = res_s1;
		if (use_mem_s1) begin
			res_mrg.tx_data = buf_rd_data;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_d;
			use_mem_s1 <= use_mem_d;
		end
		if (adv_s2) begin
			res_s2 <= res_mrg;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {4'd0, res_s2.phase, res_s2.done_kind, res_s2.rx_index, res_s2.rx_out,
		res_s2.tx_data, res_s2.cmd_read, res_s2.cmd_nbytes, res_s2.cmd_address};

endmodule

FILE: sim/i2c_master_transfer_sequencer_tb.sv
// Self-checking testbench for the I2C master transfer sequencer: directed table, then random transfers.
module i2c_master_transfer_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmts_pkg::*;

	localparam int N_EVENTS    = 1350;
	localparam int QUIET_TAIL  = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	// Op code with no meaning to the sequencer
	localparam logic [3:0] OP_UNUSED = 4'hF;

	// Error flag codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_BUSY = 2'd1;
	localparam logic [1:0] ERR_NACK = 2'd2;

	// Input transaction fields; last member sits in the lowest bits of s_tdata
	typedef struct packed {
		logic [5:0]  pad;
		logic [7:0]  ldat;
		logic [7:0]  lidx;
		logic [7:0]  rx;
		logic [7:0]  count;
		logic [1:0]  reg_bytes;
		logic [15:0] reg_addr;
		logic [6:0]  dev;
		logic        busy;
	} ev_t;

	// One row of the directed table
	typedef struct packed {
		logic [3:0] op;
		ev_t        f;
		logic       typed;
		res_t       want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	// Predicted sequencer state
	logic [1:0]  seq_phase;
	xfer_t       seq_kind;
	logic [6:0]  seq_target;
	logic [15:0] seq_reg_addr;
	logic [1:0]  seq_reg_bytes;
	logic [7:0]  seq_length;
	logic [7:0]  seq_data_cnt;
	logic [1:0]  seq_addr_cnt;
	logic [1:0]  seq_error;
	logic [7:0]  tx_bytes [256];
	bit          tx_written [256];

	res_t pending_results [$];
	row_t directed [$];

	int  errors;
	int  events_counted;
	int  results_seen;
	int  done_seen;
	int  busy_seen;
	int  cycles;
	bit  gaps_on;
	bit  stalls_on;
	bit  hold_req;
	bit  hold_done;
	bit  drain_done;

	i2c_master_transfer_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clear transfer state in the predictor
	task automatic drop_transfer();
		seq_phase     = PhaseCodeReady;
		seq_kind      = XF_NONE;
		seq_target    = '0;
		seq_reg_addr  = '0;
		seq_reg_bytes = '0;
		seq_length    = '0;
		seq_data_cnt  = '0;
		seq_addr_cnt  = '0;
		seq_error     = ERR_NONE;
	endtask

	// Predict the result of one event and advance the state
	task automatic sequence_event(input logic [3:0] op, input ev_t f, output res_t r);
		int pos;
		logic ok;
		r = '0;
		r.kind = K_NONE;
		case (op)
			OP_WRITE, OP_READ, OP_REG_WRITE, OP_REG_READ: begin
				if (f.busy || seq_phase != PhaseCodeReady) begin
					seq_error = ERR_BUSY;
					r.kind = K_BUSY;
				end else begin
					seq_kind     = xfer_t'({1'b0, op[1:0]});
					seq_target   = f.dev;
					seq_length   = f.count;
					seq_data_cnt = '0;
					seq_addr_cnt = '0;
					seq_error    = ERR_NONE;
					r.kind = K_START;
					r.cmd_address = f.dev;
					if (op == OP_REG_WRITE || op == OP_REG_READ) begin
						seq_reg_addr  = f.reg_addr;
						seq_reg_bytes = f.reg_bytes;
						seq_phase     = PhaseCodeAddr;
						r.cmd_nbytes  = {6'b0, f.reg_bytes};
					end else begin
						seq_reg_addr  = '0;
						seq_reg_bytes = '0;
						seq_phase     = (op == OP_WRITE) ? PhaseCodeTx : PhaseCodeRx;
						r.cmd_nbytes  = f.count;
						r.cmd_read    = (op == OP_READ);
					end
				end
			end
			OP_TX_READY: begin
				// Address bytes go out MSB first; positions past the top give zero
				if (seq_phase == PhaseCodeAddr) begin
					pos = int'(seq_reg_bytes) - 1 - int'(seq_addr_cnt);
					r.kind = K_TX;
					if (pos == 0)
						r.tx_data = seq_reg_addr[7:0];
					else if (pos == 1)
						r.tx_data = seq_reg_addr[15:8];
					seq_addr_cnt = seq_addr_cnt + 2'd1;
				end else if (seq_phase == PhaseCodeTx) begin
					r.kind = K_TX;
					r.tx_data = tx_bytes[seq_data_cnt];
					seq_data_cnt = seq_data_cnt + 8'd1;
				end
			end
			OP_RX_READY: begin
				if (seq_phase == PhaseCodeRx) begin
					r.kind = K_RX;
					r.rx_out = f.rx;
					r.rx_index = seq_length - 8'd1 - seq_data_cnt;
					seq_data_cnt = seq_data_cnt + 8'd1;
				end
			end
			OP_STOP: begin
				if (seq_phase == PhaseCodeAddr) begin
					// End of the address phase: restart for the data phase
					if (seq_kind == XF_REG_WRITE || seq_kind == XF_REG_READ) begin
						r.kind = K_START;
						r.cmd_address = seq_target;
						r.cmd_nbytes = seq_length;
						r.cmd_read = (seq_kind == XF_REG_READ);
						seq_phase = (seq_kind == XF_REG_READ) ? PhaseCodeRx : PhaseCodeTx;
					end
				end else if (seq_phase == PhaseCodeTx || seq_phase == PhaseCodeRx) begin
					if (seq_phase == PhaseCodeTx)
						ok = (seq_kind == XF_WRITE || seq_kind == XF_REG_WRITE);
					else
						ok = (seq_kind == XF_READ || seq_kind == XF_REG_READ);
					if (ok) begin
						r.kind = K_DONE;
						r.done_kind = seq_kind[1:0];
						drop_transfer();
					end
				end
			end
			OP_NACK: begin
				seq_error = ERR_NACK;
				r.kind = K_NACK;
			end
			OP_LOAD: begin
				tx_bytes[f.lidx] = f.ldat;
				tx_written[f.lidx] = 1'b1;
			end
			default: ;
		endcase
		r.phase = seq_phase;
	endtask

	function automatic ev_t mk_ev(input logic busy, input logic [6:0] dev,
		input logic [15:0] reg_addr, input logic [1:0] reg_bytes, input logic [7:0] count,
		input logic [7:0] rx, input logic [7:0] lidx, input logic [7:0] ldat);
		ev_t f;
		f = '{pad: '0, ldat: ldat, lidx: lidx, rx: rx, count: count, reg_bytes: reg_bytes,
			reg_addr: reg_addr, dev: dev, busy: busy};
		return f;
	endfunction

	function automatic res_t mk_res(input kind_t kind, input logic [6:0] addr,
		input logic [7:0] nbytes, input logic rd, input logic [7:0] tx, input logic [7:0] rxo,
		input logic [7:0] rxi, input xfer_t dk, input logic [1:0] ph);
		res_t r;
		r = '{kind: kind, cmd_address: addr, cmd_nbytes: nbytes, cmd_read: rd, tx_data: tx,
			rx_out: rxo, rx_index: rxi, done_kind: dk[1:0], phase: ph};
		return r;
	endfunction

	function automatic ev_t rand_ev();
		return mk_ev(1'($urandom_range(0, 1)), 7'($urandom), 16'($urandom), 2'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	// Offer one transaction, wait for acceptance, then record what it should produce
	task automatic drive(input logic [3:0] op, input ev_t f, input bit typed, input res_t want);
		res_t r;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sequence_event(op, f, r);
		pending_results.push_back(typed ? want : r);
		if (r.kind != K_NONE || op == OP_LOAD)
			events_counted++;
	endtask

	// Send an event; fill the buffer entry first if a tx byte would read it unwritten
	task automatic send_event(input logic [3:0] op, input ev_t f);
		ev_t lf;
		if (op == OP_TX_READY && seq_phase == PhaseCodeTx && !tx_written[seq_data_cnt]) begin
			lf = rand_ev();
			lf.lidx = seq_data_cnt;
			drive(OP_LOAD, lf, 1'b0, '0);
		end
		drive(op, f, 1'b0, '0);
	endtask

	// Drop valid and hold off until every result has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic send_noise();
		send_event(4'($urandom_range(0, 15)), rand_ev());
	endtask

	// One well-formed transfer with random content and some stray events
	task automatic run_transfer();
		ev_t f;
		int n;
		f = rand_ev();
		f.busy = ($urandom_range(0, 9) == 0);
		f.count = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		f.reg_bytes = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		repeat ($urandom_range(0, 3)) begin
			send_event(OP_LOAD, rand_ev());
		end
		send_event(4'($urandom_range(0, 3)), f);
		if (seq_phase == PhaseCodeReady)
			return;
		// Address phase: register bytes, sometimes one or two extra
		if (seq_phase == PhaseCodeAddr) begin
			n = seq_reg_bytes + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
			repeat (n) begin
				send_event(OP_TX_READY, rand_ev());
			end
			if ($urandom_range(0, 9) == 0)
				send_event(OP_NACK, rand_ev());
			send_event(OP_STOP, rand_ev());
		end
		// Data phase: full length when short, otherwise usually cut short
		n = seq_length;
		if (n > 8 && $urandom_range(0, 3) != 0)
			n = $urandom_range(0, 8);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			send_event((seq_phase == PhaseCodeTx) ? OP_TX_READY : OP_RX_READY, rand_ev());
		end
		send_event(OP_STOP, rand_ev());
	endtask

	// Result sink: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind: kind_t'(m_tuser), cmd_address: m_tdata[6:0], cmd_nbytes: m_tdata[14:7],
				cmd_read: m_tdata[15], tx_data: m_tdata[23:16], rx_out: m_tdata[31:24],
				rx_index: m_tdata[39:32], done_kind: m_tdata[41:40], phase: m_tdata[43:42]};
			results_seen++;
			if (got.kind == K_DONE)
				done_seen++;
			if (got.kind == K_BUSY)
				busy_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result: expected none, actual kind %0d tdata %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("cmd_address", want.cmd_address, got.cmd_address);
				check_field("cmd_nbytes", want.cmd_nbytes, got.cmd_nbytes);
				check_field("cmd_read", want.cmd_read, got.cmd_read);
				check_field("tx_data", want.tx_data, got.tx_data);
				check_field("rx_out", want.rx_out, got.rx_out);
				check_field("rx_index", want.rx_index, got.rx_index);
				check_field("done_kind", want.done_kind, got.done_kind);
				check_field("phase", want.phase, got.phase);
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_WRITE;
		errors    = 0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		events_counted = 0;
		results_seen = 0;
		done_seen = 0;
		busy_seen = 0;
		drop_transfer();
		foreach (tx_written[i]) tx_written[i] = 1'b0;

		// Directed table: reset state, wrong-phase events, rejects, every transfer kind
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(K_NONE, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeReady)});
		directed.push_back(row_t'{OP_UNUSED, mk_ev(1, 7'h7F, 16'hFFFF, 2'd3, 8'hFF, 8'hFF,
			8'hFF, 8'hFF), 1'b1, mk_res(K_NONE, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeReady)});
		directed.push_back(row_t'{OP_NACK, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(K_NACK, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeReady)});
		directed.push_back(row_t'{OP_WRITE, mk_ev(1, 7'h7F, 16'hFFFF, 2'd3, 8'hFF, 8'hFF,
			8'hFF, 8'hFF), 1'b1, mk_res(K_BUSY, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeReady)});
		directed.push_back(row_t'{OP_LOAD, mk_ev(0, 0, 0, 0, 0, 0, 8'h00, 8'hFF), 1'b0, '0});
		directed.push_back(row_t'{OP_LOAD, mk_ev(0, 0, 0, 0, 0, 0, 8'hFF, 8'h00), 1'b0, '0});
		directed.push_back(row_t'{OP_LOAD, mk_ev(0, 0, 0, 0, 0, 0, 8'h01, 8'hA5), 1'b0, '0});
		directed.push_back(row_t'{OP_WRITE, mk_ev(0, 7'h7F, 0, 0, 8'd2, 0, 0, 0), 1'b1,
			mk_res(K_START, 7'h7F, 8'd2, 0, 0, 0, 0, XF_WRITE, PhaseCodeTx)});
		directed.push_back(row_t'{OP_READ, mk_ev(0, 7'h01, 0, 0, 8'd1, 0, 0, 0), 1'b1,
			mk_res(K_BUSY, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeTx)});
		directed.push_back(row_t'{OP_TX_READY, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_TX_READY, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_RX_READY, mk_ev(0, 0, 0, 0, 0, 8'h5A, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(K_DONE, 0, 0, 0, 0, 0, 0, XF_WRITE, PhaseCodeReady)});
		directed.push_back(row_t'{OP_READ, mk_ev(0, 0, 0, 0, 8'd0, 0, 0, 0), 1'b1,
			mk_res(K_START, 0, 0, 1, 0, 0, 0, XF_WRITE, PhaseCodeRx)});
		directed.push_back(row_t'{OP_RX_READY, mk_ev(0, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b1,
			mk_res(K_RX, 0, 0, 0, 0, 8'hFF, 8'hFF, XF_WRITE, PhaseCodeRx)});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(K_DONE, 0, 0, 0, 0, 0, 0, XF_READ, PhaseCodeReady)});
		directed.push_back(row_t'{OP_REG_WRITE, mk_ev(0, 7'h05, 16'hABCD, 2'd2, 8'd1, 0, 0, 0),
			1'b0, '0});
		repeat (3) directed.push_back(row_t'{OP_TX_READY, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0,
			'0});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_TX_READY, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_REG_READ, mk_ev(0, 7'h40, 16'h0000, 2'd0, 8'hFF, 0, 0, 0),
			1'b0, '0});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_NACK, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed.push_back(row_t'{OP_STOP, mk_ev(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(K_DONE, 0, 0, 0, 0, 0, 0, XF_REG_READ, PhaseCodeReady)});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			drive(directed[i].op, directed[i].f, directed[i].typed, directed[i].want);
		drain();

		// Random part: mostly whole transfers, some stray events
		while (events_counted < N_EVENTS) begin
			if (events_counted >= N_EVENTS - QUIET_TAIL) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			if (!hold_done && events_counted >= N_EVENTS / 3) begin
				hold_done = 1'b1;
				hold_req = 1'b1;
			end
			if (!drain_done && events_counted >= (2 * N_EVENTS) / 3) begin
				drain_done = 1'b1;
				drain();
			end
			if ($urandom_range(0, 9) < 7)
				run_transfer();
			else
				repeat ($urandom_range(1, 4)) send_noise();
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d events through directed and random transfers; %0d results checked,",
			events_counted, results_seen);
		$display("%0d transfers completed, %0d requests rejected as busy, %0d mismatches.",
			done_seen, busy_seen, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/i2cmts_pkg.sv
src/i2cmts_tx_buffer.sv
src/i2c_master_transfer_sequencer.sv
sim/i2c_master_transfer_sequencer_tb.sv
